@@ design/lru_k_frame_replacer_macros.svh @@
// Assertion helpers shared by the replacer modules.
`ifndef LRU_K_FRAME_REPLACER_MACROS_SVH
`define LRU_K_FRAME_REPLACER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LKR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lru_k replacer check failed");

// Next-cycle implication, disabled during reset.
`define LKR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lru_k replacer check failed");

`endif

@@ design/lkr_pkg.sv @@
package lkr_pkg;

    localparam int FRAMES   = 64;
    localparam int K_MAX    = 8;
    localparam int TS_WIDTH = 32;

    localparam int FRAME_W  = $clog2(FRAMES);
    localparam int RING_W   = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int ACC_W    = $clog2(K_MAX + 1);
    localparam int TOTAL_W  = $clog2(FRAMES + 1);
    localparam int META_W   = ACC_W + RING_W;
    localparam int HIST_AW  = FRAME_W + RING_W;
    localparam int HIST_DEPTH = FRAMES * (2 ** RING_W);

    localparam int CMD_W     = 3;
    localparam int STATUS_W  = 2;
    localparam int K_CFG_W   = 4;
    localparam int FC_CFG_W  = 7;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CMD_W-1:0] CMD_RECORD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_EVICT  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_K_DEPTH     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'd1;

    typedef struct packed {
        logic [ACC_W-1:0]  count;
        logic [RING_W-1:0] head;
    } meta_t;

    // controller -> datapath
    typedef struct packed {
        logic               accept;
        logic               meta_scan;
        logic               scan_issue;
        logic               scan_clear;
        logic               rec_write;
        logic               finish;
        logic [FRAME_W-1:0] scan_frame;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic rec_go;
        logic evict_go;
    } dp_stat_t;

endpackage

@@ design/lkr_ram.sv @@
module lkr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/lkr_ctrl.sv @@
`include "lru_k_frame_replacer_macros.svh"

module lkr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  lkr_pkg::dp_stat_t stat,
    output lkr_pkg::dp_cmd_t  cmd
);

    import lkr_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_REC    = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRAIN1 = 3'd3;
    localparam logic [2:0] S_DRAIN2 = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    localparam logic [FRAME_W-1:0] LAST_FRAME = FRAME_W'(FRAMES - 1);

    logic [2:0]         state_reg, state_next;
    logic [FRAME_W-1:0] scan_idx_reg, scan_idx_next;
    logic               out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        cmd            = '0;
        cmd.scan_frame = scan_idx_reg;
        in_ready       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (stat.rec_go)
                    begin
                        state_next = S_REC;
                    end
                    else if (stat.evict_go)
                    begin
                        cmd.scan_clear = 1'b1;
                        scan_idx_next  = '0;
                        state_next     = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_REC:
            begin
                cmd.rec_write = 1'b1;
                state_next    = S_DONE;
            end
            S_SCAN:
            begin
                cmd.meta_scan  = 1'b1;
                cmd.scan_issue = 1'b1;
                if (scan_idx_reg == LAST_FRAME)
                begin
                    state_next = S_DRAIN1;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            S_DRAIN1:
            begin
                state_next = S_DRAIN2;
            end
            S_DRAIN2:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold the finished request until the result register frees up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `LKR_ASSERT_NEXT(a_evict_starts_scan, in_valid && in_ready && stat.evict_go, state_reg == S_SCAN && scan_idx_reg == '0)
    `LKR_ASSERT_NEXT(a_drain_ends_done, state_reg == S_DRAIN2, state_reg == S_DONE)

endmodule

@@ design/lkr_datapath.sv @@
`include "lru_k_frame_replacer_macros.svh"

module lkr_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [lkr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lkr_pkg::CFG_W-1:0]         cfg_data,
    input  logic [lkr_pkg::CMD_W-1:0]         command,
    input  logic [lkr_pkg::FRAME_W-1:0]       frame,
    input  lkr_pkg::dp_cmd_t                  cmd,
    output lkr_pkg::dp_stat_t                 stat,
    output logic [lkr_pkg::FRAME_W-1:0]       victim_frame,
    output logic                              victim_valid,
    output logic [lkr_pkg::STATUS_W-1:0]      status,
    output logic [lkr_pkg::TOTAL_W-1:0]       evictable_count
);

    import lkr_pkg::*;

    localparam int EF_W = (FC_CFG_W > TOTAL_W) ? FC_CFG_W : TOTAL_W;
    localparam int KX_W = (K_CFG_W > ACC_W) ? K_CFG_W : ACC_W;
    localparam int POS_W = ACC_W + 1;

    // configuration
    logic [K_CFG_W-1:0]  k_depth_reg, k_depth_next;
    logic [FC_CFG_W-1:0] frame_count_reg, frame_count_next;

    // per-frame flags and globals
    logic [FRAMES-1:0]   tracked_reg, tracked_next;
    logic [FRAMES-1:0]   evictable_reg, evictable_next;
    logic [TS_WIDTH-1:0] time_reg, time_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;

    // latched request
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [FRAME_W-1:0]  frame_reg, frame_next;
    logic                in_range_reg, in_range_next;

    // scan pipeline
    logic                p1_valid_reg, p1_valid_next;
    logic [FRAME_W-1:0]  p1_frame_reg, p1_frame_next;
    logic                p2_valid_reg, p2_valid_next;
    logic [FRAME_W-1:0]  p2_frame_reg, p2_frame_next;
    logic                p2_inf_reg, p2_inf_next;
    logic                best_found_reg, best_found_next;
    logic                best_inf_reg, best_inf_next;
    logic [TS_WIDTH-1:0] best_age_reg, best_age_next;
    logic [FRAME_W-1:0]  best_frame_reg, best_frame_next;

    // result
    logic [FRAME_W-1:0]  victim_reg, victim_next;
    logic                vvalid_reg, vvalid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [TOTAL_W-1:0]  count_reg, count_next;

    // memories
    logic                meta_we;
    logic [FRAME_W-1:0]  meta_raddr;
    meta_t               meta_wdata, meta_rdata, meta_old;
    logic                hist_we;
    logic [HIST_AW-1:0]  hist_waddr, hist_raddr;
    logic [TS_WIDTH-1:0] hist_rdata;

    logic [EF_W-1:0]     fc_ext, eff_frames;
    logic [KX_W-1:0]     kx;
    logic [ACC_W-1:0]    k_eff;
    logic                in_range;

    logic                s1_inf;
    logic [ACC_W-1:0]    s1_back;
    logic [POS_W-1:0]    s1_sum, s1_pos;
    logic [TS_WIDTH-1:0] s2_age;
    logic                s2_take;

    always_comb
    begin
        fc_ext     = EF_W'(frame_count_reg);
        eff_frames = (fc_ext > EF_W'(FRAMES)) ? EF_W'(FRAMES) : fc_ext;
        in_range   = EF_W'(frame) < eff_frames;
        kx         = KX_W'(k_depth_reg);
        if (kx == '0)
        begin
            k_eff = ACC_W'(1);
        end
        else if (kx > KX_W'(K_MAX))
        begin
            k_eff = ACC_W'(K_MAX);
        end
        else
        begin
            k_eff = ACC_W'(kx);
        end
    end

    assign stat.rec_go   = (command == CMD_RECORD) && in_range;
    assign stat.evict_go = (command == CMD_EVICT);

    assign meta_raddr = cmd.meta_scan ? cmd.scan_frame : frame;
    assign meta_old   = tracked_reg[frame_reg] ? meta_rdata : '0;

    // stage 1: locate the stamp that sets this frame's distance
    always_comb
    begin
        s1_inf  = meta_rdata.count < k_eff;
        s1_back = s1_inf ? ACC_W'(1) : k_eff;
        s1_sum  = POS_W'(meta_rdata.head) + POS_W'(K_MAX) - POS_W'(s1_back);
        s1_pos  = (s1_sum >= POS_W'(K_MAX)) ? s1_sum - POS_W'(K_MAX) : s1_sum;
    end

    assign hist_raddr = {p1_frame_reg, RING_W'(s1_pos)};

    // stage 2: age and compare against the current best
    always_comb
    begin
        s2_age = time_reg - hist_rdata;
        if (p2_inf_reg)
        begin
            s2_take = !best_inf_reg || (s2_age > best_age_reg);
        end
        else
        begin
            s2_take = !best_inf_reg && (!best_found_reg || (s2_age > best_age_reg));
        end
    end

    always_comb
    begin
        k_depth_next     = k_depth_reg;
        frame_count_next = frame_count_reg;
        tracked_next     = tracked_reg;
        evictable_next   = evictable_reg;
        time_next        = time_reg;
        total_next       = total_reg;
        cmd_next         = cmd_reg;
        frame_next       = frame_reg;
        in_range_next    = in_range_reg;
        p1_valid_next    = 1'b0;
        p1_frame_next    = cmd.scan_frame;
        p2_valid_next    = p1_valid_reg;
        p2_frame_next    = p1_frame_reg;
        p2_inf_next      = s1_inf;
        best_found_next  = best_found_reg;
        best_inf_next    = best_inf_reg;
        best_age_next    = best_age_reg;
        best_frame_next  = best_frame_reg;
        victim_next      = victim_reg;
        vvalid_next      = vvalid_reg;
        status_next      = status_reg;
        count_next       = count_reg;
        meta_we          = 1'b0;
        meta_wdata       = meta_old;
        hist_we          = 1'b0;
        hist_waddr       = {frame_reg, meta_old.head};

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_K_DEPTH:     k_depth_next = cfg_data[K_CFG_W-1:0];
                CFG_FRAME_COUNT: frame_count_next = cfg_data[FC_CFG_W-1:0];
                default:         ;
            endcase
        end

        if (cmd.accept)
        begin
            cmd_next      = command;
            frame_next    = frame;
            in_range_next = in_range;
        end

        if (cmd.scan_clear)
        begin
            best_found_next = 1'b0;
            best_inf_next   = 1'b0;
        end

        if (cmd.scan_issue)
        begin
            p1_valid_next = tracked_reg[cmd.scan_frame] & evictable_reg[cmd.scan_frame];
        end

        if (p2_valid_reg && s2_take)
        begin
            best_found_next = 1'b1;
            best_inf_next   = p2_inf_reg;
            best_age_next   = s2_age;
            best_frame_next = p2_frame_reg;
        end

        if (cmd.rec_write)
        begin
            hist_we    = 1'b1;
            meta_we    = 1'b1;
            if (meta_old.count != ACC_W'(K_MAX))
            begin
                meta_wdata.count = meta_old.count + 1'b1;
            end
            if (meta_old.head == RING_W'(K_MAX - 1))
            begin
                meta_wdata.head = '0;
            end
            else
            begin
                meta_wdata.head = meta_old.head + 1'b1;
            end
            tracked_next[frame_reg] = 1'b1;
            time_next = time_reg + 1'b1;
        end

        if (cmd.finish)
        begin
            victim_next = '0;
            vvalid_next = 1'b0;
            status_next = ST_OK;
            case (cmd_reg)
                CMD_RECORD:
                begin
                    if (!in_range_reg)
                    begin
                        status_next = ST_RANGE;
                    end
                end
                CMD_SET, CMD_CLEAR:
                begin
                    if (!in_range_reg)
                    begin
                        status_next = ST_RANGE;
                    end
                    else if (!tracked_reg[frame_reg])
                    begin
                        status_next = ST_REJECT;
                    end
                    else if (cmd_reg == CMD_SET && !evictable_reg[frame_reg])
                    begin
                        evictable_next[frame_reg] = 1'b1;
                        total_next = total_reg + 1'b1;
                    end
                    else if (cmd_reg == CMD_CLEAR && evictable_reg[frame_reg])
                    begin
                        evictable_next[frame_reg] = 1'b0;
                        total_next = total_reg - 1'b1;
                    end
                end
                CMD_REMOVE:
                begin
                    if (!in_range_reg)
                    begin
                        status_next = ST_RANGE;
                    end
                    else if (!tracked_reg[frame_reg] || !evictable_reg[frame_reg])
                    begin
                        status_next = ST_REJECT;
                    end
                    else
                    begin
                        tracked_next[frame_reg]   = 1'b0;
                        evictable_next[frame_reg] = 1'b0;
                        total_next = total_reg - 1'b1;
                    end
                end
                CMD_EVICT:
                begin
                    if (best_found_reg)
                    begin
                        tracked_next[best_frame_reg]   = 1'b0;
                        evictable_next[best_frame_reg] = 1'b0;
                        total_next  = total_reg - 1'b1;
                        victim_next = best_frame_reg;
                        vvalid_next = 1'b1;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
            count_next = total_next;
        end
    end

    lkr_ram #(
        .WIDTH (META_W),
        .DEPTH (FRAMES)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (frame_reg),
        .wdata (meta_wdata),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    lkr_ram #(
        .WIDTH (TS_WIDTH),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (time_reg),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_depth_reg     <= K_CFG_W'(2);
            frame_count_reg <= FC_CFG_W'(64);
            tracked_reg     <= '0;
            evictable_reg   <= '0;
            time_reg        <= '0;
            total_reg       <= '0;
            p1_valid_reg    <= 1'b0;
            p2_valid_reg    <= 1'b0;
            best_found_reg  <= 1'b0;
            best_inf_reg    <= 1'b0;
        end
        else
        begin
            k_depth_reg     <= k_depth_next;
            frame_count_reg <= frame_count_next;
            tracked_reg     <= tracked_next;
            evictable_reg   <= evictable_next;
            time_reg        <= time_next;
            total_reg       <= total_next;
            p1_valid_reg    <= p1_valid_next;
            p2_valid_reg    <= p2_valid_next;
            best_found_reg  <= best_found_next;
            best_inf_reg    <= best_inf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        frame_reg      <= frame_next;
        in_range_reg   <= in_range_next;
        p1_frame_reg   <= p1_frame_next;
        p2_frame_reg   <= p2_frame_next;
        p2_inf_reg     <= p2_inf_next;
        best_age_reg   <= best_age_next;
        best_frame_reg <= best_frame_next;
        victim_reg     <= victim_next;
        vvalid_reg     <= vvalid_next;
        status_reg     <= status_next;
        count_reg      <= count_next;
    end

    assign victim_frame    = victim_reg;
    assign victim_valid    = vvalid_reg;
    assign status          = status_reg;
    assign evictable_count = count_reg;

    `LKR_ASSERT_IMP(a_total_matches_flags, 1'b1, total_reg == TOTAL_W'($countones(evictable_reg)))
    `LKR_ASSERT_IMP(a_evictable_is_tracked, 1'b1, (evictable_reg & ~tracked_reg) == '0)

endmodule

@@ design/lru_k_frame_replacer.sv @@
// Channel   Handshake              Payload
// in        in_valid / in_ready    command, frame
// out       out_valid / out_ready  victim_frame, victim_valid, status, evictable_count
// cfg       cfg_write              cfg_index, cfg_data
//
// In-range record writes history and metadata in S_REC; flag commands and remove go to S_DONE.
// Evict scans one frame per cycle through the metadata and history RAM reads, then drains.
// Reset clears tracked/evictable flags, time counter, evictable total; RAMs are not cleared.
// A new request is taken while an earlier result waits; a result stalled at out holds the next
// request in its final cycle.
module lru_k_frame_replacer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [lkr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lkr_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [lkr_pkg::CMD_W-1:0]       command,
    input  logic [lkr_pkg::FRAME_W-1:0]     frame,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [lkr_pkg::FRAME_W-1:0]     victim_frame,
    output logic                            victim_valid,
    output logic [lkr_pkg::STATUS_W-1:0]    status,
    output logic [lkr_pkg::TOTAL_W-1:0]     evictable_count
);

    import lkr_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    lkr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    lkr_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .command         (command),
        .frame           (frame),
        .cmd             (dp_cmd),
        .stat            (dp_stat),
        .victim_frame    (victim_frame),
        .victim_valid    (victim_valid),
        .status          (status),
        .evictable_count (evictable_count)
    );

endmodule
